// File: hdl/mlfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_pkg
// Shared types and constants of the feedback scheduler.
// ----------------------------------------------------------------------------
package mlfs_pkg;

	localparam int unsigned LEVELS  = 4;
	localparam int unsigned LVL_W   = 2;
	localparam int unsigned ID_W    = 4;
	localparam int unsigned SLICE_W = 4;
	localparam int unsigned RUN_W   = 16;
	localparam int unsigned TURN_W  = 16;

	localparam logic OP_ADMIT = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam logic [LVL_W-1:0] LVL_TOP = 2'd0;
	localparam logic [LVL_W-1:0] LVL_BOT = 2'd3;

	localparam logic STAT_OK   = 1'b0;
	localparam logic STAT_FULL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADMIT,
		ST_EVAL,
		ST_POP,
		ST_FETCH,
		ST_LOAD,
		ST_INC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic admit;
		logic eval;
		logic pop;
		logic fetch;
		logic load;
		logic inc;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic cpu_busy;
		logic any_queued;
	} sts_t;

	typedef struct packed {
		logic [LVL_W-1:0]   level;
		logic [SLICE_W-1:0] slice;
		logic [RUN_W-1:0]   used;
		logic [RUN_W-1:0]   needed;
	} rec_t;

endpackage

// File: hdl/multilevel_feedback_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler
// Four-level feedback queue scheduler with quanta of 1, 2, 4 and 8 ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Present op, task_id and run_time with start high; the word is taken at
//   the edge where start is high and busy is low. op 0 admits a task at
//   level 0, op 1 advances the scheduler by one tick.
//   Each word gives one result word on running_valid .. status, marked by a
//   one-cycle result_valid pulse; the receiver cannot hold it off.
//   After accept, an admit steps through EVAL, ADMIT and EMIT; a tick that
//   keeps or idles the CPU steps through EVAL, POP, INC and EMIT; a tick that
//   dispatches adds FETCH and LOAD after POP for the registered reads of the
//   queue memory, then of the task record memory. One word at a time; busy
//   is low again in the cycle result_valid is high.
//   Reset empties all queues, idles the CPU and clears time; task records
//   and queue entries are undefined until written.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler #(
	parameter int unsigned MAX_TASKS = 16,
	parameter int unsigned TIME_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic         op,
	input  logic [3:0]   task_id,
	input  logic [15:0]  run_time,
	output logic         result_valid,
	output logic         running_valid,
	output logic [3:0]   running_id,
	output logic         done_valid,
	output logic [3:0]   done_id,
	output logic [15:0]  turnaround,
	output logic         status
);

	mlfs_pkg::cmd_t cmd;
	mlfs_pkg::sts_t sts;

	mlfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	mlfs_datapath #(
		.MAX_TASKS (MAX_TASKS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.op            (op),
		.task_id       (task_id),
		.run_time      (run_time),
		.result_valid  (result_valid),
		.running_valid (running_valid),
		.running_id    (running_id),
		.done_valid    (done_valid),
		.done_id       (done_id),
		.turnaround    (turnaround),
		.status        (status)
	);

`ifndef SYNTHESIS
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy) else $error("result while busy");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accept without busy");
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid) else $error("repeated result");
	a_idle_id: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !running_valid |-> running_id == 4'd0)
		else $error("idle cpu with id");
`endif

endmodule

// File: hdl/mlfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_ctrl
// Sequencer: steps one admit or tick word through the datapath.
// ----------------------------------------------------------------------------
module mlfs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  mlfs_pkg::sts_t sts,
	output mlfs_pkg::cmd_t cmd
);

	mlfs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mlfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		case (state_q)
			mlfs_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.capture = 1'b1;
					state_d = mlfs_pkg::ST_EVAL;
				end
			end
			mlfs_pkg::ST_EVAL: begin
				if (sts.op == mlfs_pkg::OP_ADMIT) begin
					state_d = mlfs_pkg::ST_ADMIT;
				end else begin
					cmd.eval = 1'b1;
					state_d = mlfs_pkg::ST_POP;
				end
			end
			mlfs_pkg::ST_ADMIT: begin
				cmd.admit = 1'b1;
				state_d = mlfs_pkg::ST_EMIT;
			end
			mlfs_pkg::ST_POP: begin
				if (!sts.cpu_busy && sts.any_queued) begin
					cmd.pop = 1'b1;
					state_d = mlfs_pkg::ST_FETCH;
				end else begin
					state_d = mlfs_pkg::ST_INC;
				end
			end
			mlfs_pkg::ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = mlfs_pkg::ST_LOAD;
			end
			mlfs_pkg::ST_LOAD: begin
				cmd.load = 1'b1;
				state_d = mlfs_pkg::ST_INC;
			end
			mlfs_pkg::ST_INC: begin
				cmd.inc = 1'b1;
				state_d = mlfs_pkg::ST_EMIT;
			end
			mlfs_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = mlfs_pkg::ST_IDLE;
			end
			default: begin
				state_d = mlfs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/mlfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfs_datapath
// Task records, level queues, running-task registers and result word.
// ----------------------------------------------------------------------------
module mlfs_datapath #(
	parameter int unsigned MAX_TASKS = 16,
	parameter int unsigned TIME_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mlfs_pkg::cmd_t                cmd,
	output mlfs_pkg::sts_t                sts,
	input  logic                          op,
	input  logic [mlfs_pkg::ID_W-1:0]     task_id,
	input  logic [mlfs_pkg::RUN_W-1:0]    run_time,
	output logic                          result_valid,
	output logic                          running_valid,
	output logic [mlfs_pkg::ID_W-1:0]     running_id,
	output logic                          done_valid,
	output logic [mlfs_pkg::ID_W-1:0]     done_id,
	output logic [mlfs_pkg::TURN_W-1:0]   turnaround,
	output logic                          status
);

	localparam int unsigned TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CW = $clog2(MAX_TASKS + 1);
	localparam int unsigned SW = TW + 1;
	localparam logic [SW-1:0] MAX_S = SW'(MAX_TASKS);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_TASKS);

	logic                          op_q;
	logic [mlfs_pkg::ID_W-1:0]     id_q;
	logic [mlfs_pkg::RUN_W-1:0]    need_q;
	logic [TIME_BITS-1:0]          time_q;
	logic                          busy_q;
	logic [mlfs_pkg::ID_W-1:0]     cpu_q;
	mlfs_pkg::rec_t                cur_q;
	logic [TIME_BITS-1:0]          cur_start_q;
	logic [CW-1:0]                 count_q [mlfs_pkg::LEVELS];
	logic [TW-1:0]                 head_q  [mlfs_pkg::LEVELS];
	logic [mlfs_pkg::ID_W-1:0]     fifo_mem [mlfs_pkg::LEVELS][MAX_TASKS];
	logic [mlfs_pkg::ID_W-1:0]     fifo_rd_q;
	mlfs_pkg::rec_t                rec_mem [MAX_TASKS];
	logic [TIME_BITS-1:0]          start_mem [MAX_TASKS];
	mlfs_pkg::rec_t                rec_rd_q;
	logic [TIME_BITS-1:0]          start_rd_q;
	logic                          res_done_q;
	logic [mlfs_pkg::ID_W-1:0]     res_id_q;
	logic [mlfs_pkg::TURN_W-1:0]   res_turn_q;
	logic                          res_stat_q;

	logic                          id_ok;
	logic                          retire;
	logic                          demote;
	logic [mlfs_pkg::LVL_W-1:0]    next_lvl;
	logic                          push_en;
	logic [mlfs_pkg::LVL_W-1:0]    push_lvl;
	logic [mlfs_pkg::ID_W-1:0]     push_id;
	logic                          push_full;
	logic [SW-1:0]                 tail_sum;
	logic [TW-1:0]                 tail;
	logic [mlfs_pkg::LVL_W-1:0]    pop_lvl;
	logic                          any;
	logic                          rec_we;
	logic [mlfs_pkg::ID_W-1:0]     rec_wid;
	mlfs_pkg::rec_t                rec_wd;
	logic [TIME_BITS-1:0]          start_wd;
	logic [TIME_BITS-1:0]          turn_full;

	assign id_ok    = 32'(id_q) < MAX_TASKS;
	assign retire   = busy_q && (cur_q.used == cur_q.needed);
	assign demote   = busy_q && !retire &&
		(cur_q.slice == (mlfs_pkg::SLICE_W'(1) << cur_q.level));
	assign next_lvl = (cur_q.level == mlfs_pkg::LVL_BOT) ? mlfs_pkg::LVL_BOT
		: cur_q.level + mlfs_pkg::LVL_W'(1);
	assign turn_full = time_q - cur_start_q;

	always_comb begin
		push_en  = 1'b0;
		push_lvl = mlfs_pkg::LVL_TOP;
		push_id  = id_q;
		if (cmd.admit && id_ok) begin
			push_en = 1'b1;
		end else if (cmd.eval && demote) begin
			push_en  = 1'b1;
			push_lvl = next_lvl;
			push_id  = cpu_q;
		end
	end

	assign push_full = count_q[push_lvl] == MAX_C;
	assign tail_sum  = SW'(head_q[push_lvl]) + SW'(count_q[push_lvl]);
	assign tail      = (tail_sum >= MAX_S) ? TW'(tail_sum - MAX_S) : TW'(tail_sum);

	always_comb begin
		any     = 1'b0;
		pop_lvl = mlfs_pkg::LVL_TOP;
		for (int i = mlfs_pkg::LEVELS - 1; i >= 0; i--) begin
			if (count_q[i] != '0) begin
				any     = 1'b1;
				pop_lvl = mlfs_pkg::LVL_W'(i);
			end
		end
	end

	always_comb begin
		rec_we   = 1'b0;
		rec_wid  = id_q;
		rec_wd   = '{level: mlfs_pkg::LVL_TOP, slice: '0, used: '0, needed: need_q};
		start_wd = time_q;
		if (cmd.admit && id_ok) begin
			rec_we = 1'b1;
		end else if (cmd.eval && (retire || demote)) begin
			rec_we   = 1'b1;
			rec_wid  = cpu_q;
			start_wd = cur_start_q;
			rec_wd   = '{level: retire ? mlfs_pkg::LVL_TOP : next_lvl,
				slice: retire ? cur_q.slice : '0,
				used: cur_q.used, needed: cur_q.needed};
		end
	end

	assign sts = '{op: op_q, cpu_busy: busy_q, any_queued: any};

	always_ff @(posedge clk) begin
		if (push_en && !push_full) begin
			fifo_mem[push_lvl][tail] <= push_id;
		end
		if (cmd.pop) begin
			fifo_rd_q <= fifo_mem[pop_lvl][head_q[pop_lvl]];
		end
		if (rec_we) begin
			rec_mem[TW'(rec_wid)]   <= rec_wd;
			start_mem[TW'(rec_wid)] <= start_wd;
		end
		if (cmd.fetch) begin
			rec_rd_q   <= rec_mem[TW'(fifo_rd_q)];
			start_rd_q <= start_mem[TW'(fifo_rd_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			id_q   <= task_id;
			need_q <= run_time;
		end
		if (cmd.admit && id_ok && busy_q && (id_q == cpu_q)) begin
			cur_q       <= rec_wd;
			cur_start_q <= time_q;
		end else if (cmd.load) begin
			cur_q       <= rec_rd_q;
			cur_start_q <= start_rd_q;
		end else if (cmd.inc && busy_q) begin
			cur_q.slice <= cur_q.slice + mlfs_pkg::SLICE_W'(1);
			cur_q.used  <= cur_q.used + mlfs_pkg::RUN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q        <= '0;
			busy_q        <= 1'b0;
			cpu_q         <= '0;
			res_done_q    <= 1'b0;
			res_id_q      <= '0;
			res_turn_q    <= '0;
			res_stat_q    <= mlfs_pkg::STAT_OK;
			result_valid  <= 1'b0;
			running_valid <= 1'b0;
			running_id    <= '0;
			done_valid    <= 1'b0;
			done_id       <= '0;
			turnaround    <= '0;
			status        <= mlfs_pkg::STAT_OK;
			for (int i = 0; i < mlfs_pkg::LEVELS; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
			end
		end else begin
			result_valid <= cmd.emit;
			if (cmd.capture) begin
				res_done_q <= 1'b0;
				res_id_q   <= '0;
				res_turn_q <= '0;
				res_stat_q <= mlfs_pkg::STAT_OK;
			end
			if (push_en) begin
				if (push_full) begin
					res_stat_q <= mlfs_pkg::STAT_FULL;
				end else begin
					count_q[push_lvl] <= count_q[push_lvl] + CW'(1);
				end
			end
			if (cmd.eval && retire) begin
				busy_q     <= 1'b0;
				res_done_q <= 1'b1;
				res_id_q   <= cpu_q;
				res_turn_q <= mlfs_pkg::TURN_W'(turn_full);
			end else if (cmd.eval && demote) begin
				busy_q <= 1'b0;
			end
			if (cmd.pop) begin
				count_q[pop_lvl] <= count_q[pop_lvl] - CW'(1);
				head_q[pop_lvl]  <= (SW'(head_q[pop_lvl]) + SW'(1) == MAX_S) ? '0
					: head_q[pop_lvl] + TW'(1);
			end
			if (cmd.load) begin
				busy_q <= 1'b1;
				cpu_q  <= fifo_rd_q;
			end
			if (cmd.inc) begin
				time_q <= time_q + TIME_BITS'(1);
			end
			if (cmd.emit) begin
				running_valid <= busy_q;
				running_id    <= busy_q ? cpu_q : '0;
				done_valid    <= res_done_q;
				done_id       <= res_id_q;
				turnaround    <= res_turn_q;
				status        <= res_stat_q;
			end
		end
	end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the four-level feedback queue scheduler.
// Drives admit and tick words through the start/busy handshake, predicts each
// result word in a local scheduler model and compares every result field.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned NTASK = 16;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic        op;
		logic [3:0]  task_id;
		logic [15:0] run_time;
	} word_t;

	typedef struct packed {
		logic        running_valid;
		logic [3:0]  running_id;
		logic        done_valid;
		logic [3:0]  done_id;
		logic [15:0] turnaround;
		logic        status;
	} sched_out_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        op;
	logic [3:0]  task_id;
	logic [15:0] run_time;
	logic        result_valid;
	logic        running_valid;
	logic [3:0]  running_id;
	logic        done_valid;
	logic [3:0]  done_id;
	logic [15:0] turnaround;
	logic        status;

	multilevel_feedback_scheduler uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .task_id(task_id), .run_time(run_time),
		.result_valid(result_valid), .running_valid(running_valid),
		.running_id(running_id), .done_valid(done_valid), .done_id(done_id),
		.turnaround(turnaround), .status(status)
	);

	word_t      pending_words[$];
	sched_out_t expected_words[$];
	int         errors = 0;
	int         cycles = 0;
	bit         stim_done = 0;

	// scheduler state
	logic [15:0] now;
	logic        cpu_on;
	logic [3:0]  cpu_id;
	logic [1:0]  lvl[NTASK];
	logic [3:0]  slice[NTASK];
	logic [15:0] used[NTASK];
	logic [15:0] needed[NTASK];
	logic [15:0] started[NTASK];
	logic [3:0]  lq[mlfs_pkg::LEVELS][$];

	function automatic sched_out_t schedule(word_t w);
		sched_out_t r;
		logic [3:0] t;
		r = '0;
		if (w.op == mlfs_pkg::OP_ADMIT) begin
			lvl[w.task_id] = mlfs_pkg::LVL_TOP;
			slice[w.task_id] = '0;
			used[w.task_id] = '0;
			needed[w.task_id] = w.run_time;
			started[w.task_id] = now;
			if (lq[0].size() >= NTASK) r.status = mlfs_pkg::STAT_FULL;
			else lq[0].push_back(w.task_id);
		end else begin
			if (cpu_on) begin
				t = cpu_id;
				if (used[t] == needed[t]) begin
					lvl[t] = mlfs_pkg::LVL_TOP;
					cpu_on = 0;
					r.done_valid = 1;
					r.done_id = t;
					r.turnaround = now - started[t];
				end else if ({1'b0, slice[t]} == (5'd1 << lvl[t])) begin
					if (lvl[t] != mlfs_pkg::LVL_BOT) lvl[t]++;
					slice[t] = '0;
					if (lq[lvl[t]].size() >= NTASK) r.status = mlfs_pkg::STAT_FULL;
					else lq[lvl[t]].push_back(t);
					cpu_on = 0;
				end
			end
			if (!cpu_on) begin
				cpu_id = 0;
				for (int l = 0; l < mlfs_pkg::LEVELS; l++) begin
					if (!cpu_on && lq[l].size() != 0) begin
						cpu_id = lq[l].pop_front();
						cpu_on = 1;
					end
				end
			end
			now++;
			if (cpu_on) begin
				slice[cpu_id]++;
				used[cpu_id]++;
			end
		end
		r.running_valid = cpu_on;
		r.running_id = cpu_on ? cpu_id : 4'd0;
		return r;
	endfunction

	function automatic word_t mk(logic o, logic [3:0] id, logic [15:0] rt);
		word_t w;
		w.op = o;
		w.task_id = id;
		w.run_time = rt;
		return w;
	endfunction

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// driver
	int gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			op <= mlfs_pkg::OP_TICK;
			task_id <= '0;
			run_time <= '0;
			gap = 0;
		end else if (start && !busy) begin
			expected_words.push_back(schedule({op, task_id, run_time}));
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
			if (gap == 0 && pending_words.size() != 0) begin
				{op, task_id, run_time} <= pending_words.pop_front();
			end else begin
				start <= 1'b0;
			end
		end else if (!start) begin
			if (gap > 0) begin
				gap = gap - 1;
			end else if (pending_words.size() != 0) begin
				{op, task_id, run_time} <= pending_words.pop_front();
				start <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		sched_out_t e;
		cycles <= cycles + 1;
		if (arst_n && result_valid) begin
			if (expected_words.size() == 0) begin
				$error("result with nothing expected");
				errors++;
			end else begin
				e = expected_words.pop_front();
				if (running_valid !== e.running_valid) begin
					$error("running_valid exp %0d got %0d", e.running_valid, running_valid);
					errors++;
				end
				if (running_id !== e.running_id) begin
					$error("running_id exp %0d got %0d", e.running_id, running_id);
					errors++;
				end
				if (done_valid !== e.done_valid) begin
					$error("done_valid exp %0d got %0d", e.done_valid, done_valid);
					errors++;
				end
				if (done_id !== e.done_id) begin
					$error("done_id exp %0d got %0d", e.done_id, done_id);
					errors++;
				end
				if (turnaround !== e.turnaround) begin
					$error("turnaround exp %0d got %0d", e.turnaround, turnaround);
					errors++;
				end
				if (status !== e.status) begin
					$error("status exp %0d got %0d", e.status, status);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		now = 0;
		cpu_on = 0;
		cpu_id = 0;
		arst_n = 1'b0;
		// directed: extremes, levels 0 to 2, demotion, full level 0, tick when idle
		pending_words.push_back(mk(mlfs_pkg::OP_TICK, 4'd9, 16'hFFFF));
		pending_words.push_back(mk(mlfs_pkg::OP_ADMIT, 4'd0, 16'd1));
		pending_words.push_back(mk(mlfs_pkg::OP_ADMIT, 4'd15, 16'd20));
		pending_words.push_back(mk(mlfs_pkg::OP_ADMIT, 4'd5, 16'hFFFF));
		for (int i = 0; i < 12; i++)
			pending_words.push_back(mk(mlfs_pkg::OP_TICK, 4'hA, 16'h5555));
		for (int i = 0; i < 17; i++)
			pending_words.push_back(mk(mlfs_pkg::OP_ADMIT, 4'(i), 16'h8000));
		// random: mostly short jobs so retirements are frequent
		for (int i = 0; i < 1000; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(0, 9);
				pending_words.push_back(mk(mlfs_pkg::OP_ADMIT, 4'($urandom),
					n == 0 ? 16'($urandom) : 16'($urandom_range(1, 40))));
			end else begin
				pending_words.push_back(mk(mlfs_pkg::OP_TICK, 4'($urandom),
					16'($urandom)));
			end
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_words.size() != 0 || start || expected_words.size() != 0) begin
			@(posedge clk);
			if (cycles > CYCLE_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_words.size() == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/mlfs_pkg.sv
hdl/mlfs_ctrl.sv
hdl/mlfs_datapath.sv
hdl/multilevel_feedback_scheduler.sv
test/tb.sv
